// ===== rtl/tmms_pkg.sv =====
`default_nettype none
package tmms_pkg;

  localparam int KEY_W = 48;
  localparam int PAY_W = 26;
  localparam int TICK_W = 32;
  localparam int MAX_RELEASE = 16;
  localparam int RUN_W = 5;

  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] ORIGIN_NOW = 2'd0;
  localparam logic [1:0] ORIGIN_FRAME = 2'd1;
  localparam logic [1:0] ORIGIN_TICK = 2'd2;
  localparam logic [1:0] ORIGIN_DROP = 2'd3;

  localparam logic Q_FRAME = 1'b0;
  localparam logic Q_TICK = 1'b1;

  localparam logic [KEY_W-1:0] FRAME_NONE = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] FRAME_SIGN = {1'b1, {(KEY_W-1){1'b0}}};

  typedef logic [PAY_W-1:0] pay_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    pay_t pay;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/timed_midi_message_scheduler_top.sv =====
// channel | direction | handshake          | fields
// in_     | input     | in_valid/in_stall  | req_type, status_byte, data_one, data_two,
//         |           |                    | msg_length, frame_time, tick_time
// out_    | output    | out_valid/out_stall| status, data_one, data_two, length,
//         |           |                    | origin_code, last_of_run
// one item at a time: a clear empties both queues, an immediate or dropped send emits one result,
// a queued send shifts entries toward the tail one slot each until it finds its place, and a
// release emits each due message from the queue front in turn; queue memory reads are registered
// synchronous active-low reset empties both queues, no clearing pass
// results sit in an output register; a stalled output holds the release walk
`default_nettype none
module timed_midi_message_scheduler_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_status_byte,
  input  wire logic [7:0]  in_data_one,
  input  wire logic [7:0]  in_data_two,
  input  wire logic [1:0]  in_msg_length,
  input  wire logic signed [47:0] in_frame_time,
  input  wire logic [31:0] in_tick_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_status,
  output logic [7:0]       out_data_one,
  output logic [7:0]       out_data_two,
  output logic [1:0]       out_length,
  output logic [1:0]       out_origin_code,
  output logic             out_last_of_run
);
  import tmms_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_N = 2 << AW;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_INS_RD = 3'd3;
  localparam logic [2:0] S_INS_CMP = 3'd4;
  localparam logic [2:0] S_REL_RD = 3'd5;
  localparam logic [2:0] S_REL_CHK = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] req_r;
  pay_t pay_r;
  logic [KEY_W-1:0] frame_r;
  logic [TICK_W-1:0] tick_r;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic q_r, q_nxt;
  logic [1:0] origin_r, origin_nxt;
  logic [AW-1:0] head_r [2];
  logic [AW-1:0] head_nxt [2];
  logic [CW-1:0] count_r [2];
  logic [CW-1:0] count_nxt [2];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic have_r, have_nxt;
  pay_t cur_r, cur_nxt;

  logic out_valid_r;
  pay_t out_pay_r;
  logic [1:0] out_origin_r;
  logic out_last_r;
  logic load;
  pay_t load_pay;
  logic [1:0] load_origin;
  logic load_last;
  logic can_load;

  entry_t mem_r [MEM_N];
  entry_t rd_r;
  logic re, we;
  logic [AW:0] raddr, waddr;
  entry_t wdata;

  logic [AW-1:0] wp_dec;
  logic [AW+1:0] tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_inc;
  logic due;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem_r[raddr];
    end
  end

  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    wp_dec = (wp_r == '0) ? LAST_IDX : wp_r - AW'(1);
    tail_sum = (AW+2)'(head_r[q_nxt]) + (AW+2)'(count_r[q_nxt]);
    if (tail_sum >= (AW+2)'(QUEUE_DEPTH)) begin
      tail = AW'(tail_sum - (AW+2)'(QUEUE_DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
    head_inc = (head_r[q_r] == LAST_IDX) ? '0 : head_r[q_r] + AW'(1);
    due = (count_r[q_r] != '0) && (run_r < RUN_W'(MAX_RELEASE)) && (rd_r.key <= key_r);
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt = key_r;
    q_nxt = q_r;
    origin_nxt = origin_r;
    head_nxt = head_r;
    count_nxt = count_r;
    wp_nxt = wp_r;
    pos_nxt = pos_r;
    run_nxt = run_r;
    have_nxt = have_r;
    cur_nxt = cur_r;
    load = 1'b0;
    load_pay = pay_r;
    load_origin = origin_r;
    load_last = 1'b1;
    re = 1'b0;
    we = 1'b0;
    raddr = {q_r, head_r[q_r]};
    waddr = {q_r, wp_r};
    wdata = '{key: key_r, pay: pay_r};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        run_nxt = '0;
        have_nxt = 1'b0;
        case (req_r)
          REQ_SEND: begin
            if (tick_r != '0) begin
              q_nxt = Q_TICK;
              key_nxt = KEY_W'(tick_r);
            end else begin
              q_nxt = Q_FRAME;
              key_nxt = frame_r ^ FRAME_SIGN;
            end
            if (tick_r == '0 && frame_r == FRAME_NONE) begin
              origin_nxt = ORIGIN_NOW;
              state_nxt = S_EMIT;
            end else if (count_r[q_nxt] == DEPTH_C) begin
              origin_nxt = ORIGIN_DROP;
              state_nxt = S_EMIT;
            end else begin
              wp_nxt = tail;
              pos_nxt = count_r[q_nxt];
              state_nxt = S_INS_RD;
            end
          end
          REQ_FRAME: begin
            q_nxt = Q_FRAME;
            key_nxt = frame_r ^ FRAME_SIGN;
            origin_nxt = ORIGIN_FRAME;
            state_nxt = S_REL_RD;
          end
          REQ_TICK: begin
            q_nxt = Q_TICK;
            key_nxt = KEY_W'(tick_r);
            origin_nxt = ORIGIN_TICK;
            state_nxt = S_REL_RD;
          end
          default: begin
            count_nxt[0] = '0;
            count_nxt[1] = '0;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_EMIT: begin
        if (can_load) begin
          load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INS_RD: begin
        if (pos_r == '0) begin
          we = 1'b1;
          count_nxt[q_r] = count_r[q_r] + CW'(1);
          state_nxt = S_IDLE;
        end else begin
          re = 1'b1;
          raddr = {q_r, wp_dec};
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (rd_r.key > key_r) begin
          wdata = rd_r;
          wp_nxt = wp_dec;
          pos_nxt = pos_r - CW'(1);
          state_nxt = S_INS_RD;
        end else begin
          count_nxt[q_r] = count_r[q_r] + CW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_REL_RD: begin
        re = 1'b1;
        state_nxt = S_REL_CHK;
      end
      S_REL_CHK: begin
        if (!have_r || can_load) begin
          if (have_r) begin
            load = 1'b1;
            load_pay = cur_r;
            load_last = !due;
          end
          if (due) begin
            cur_nxt = rd_r.pay;
            have_nxt = 1'b1;
            head_nxt[q_r] = head_inc;
            count_nxt[q_r] = count_r[q_r] - CW'(1);
            run_nxt = run_r + RUN_W'(1);
            state_nxt = S_REL_RD;
          end else begin
            have_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r[0] <= '0;
      count_r[1] <= '0;
      head_r[0] <= '0;
      head_r[1] <= '0;
      have_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r <= head_nxt;
      have_r <= have_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r <= in_req_type;
      pay_r <= {in_msg_length, in_data_two, in_data_one, in_status_byte};
      frame_r <= in_frame_time;
      tick_r <= in_tick_time;
    end
    key_r <= key_nxt;
    q_r <= q_nxt;
    origin_r <= origin_nxt;
    wp_r <= wp_nxt;
    pos_r <= pos_nxt;
    run_r <= run_nxt;
    cur_r <= cur_nxt;
    if (load) begin
      out_pay_r <= load_pay;
      out_origin_r <= load_origin;
      out_last_r <= load_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_pay_r[7:0];
  assign out_data_one = out_pay_r[15:8];
  assign out_data_two = out_pay_r[23:16];
  assign out_length = out_pay_r[25:24];
  assign out_origin_code = out_origin_r;
  assign out_last_of_run = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/tmms_checker.sv =====
`default_nettype none
module tmms_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_status,
  input wire logic [1:0] out_origin_code,
  input wire logic       out_last_of_run
);
  import tmms_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted item did not make the block busy");

  a_single_results_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_origin_code == ORIGIN_NOW || out_origin_code == ORIGIN_DROP))
      |-> out_last_of_run)
    else $error("immediate or dropped item not marked last");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)))
    else $error("stalled output item changed");

endmodule

bind timed_midi_message_scheduler_top tmms_checker u_tmms_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_status(out_status),
  .out_origin_code(out_origin_code),
  .out_last_of_run(out_last_of_run)
);
`default_nettype wire
